// ----- design/pssd_pkg.sv -----
// Shared types and constants of the polyphonic sine synthesizer.
`default_nettype none

package pssd_pkg;

	// Default sizes handed to the top level.
	localparam int VOICES_DEF     = 13;
	localparam int SINE_DEPTH_DEF = 1024;

	// Field and register widths.
	localparam int VOL_W   = 28;
	localparam int FADE_W  = 16;
	localparam int PHASE_W = 32;
	localparam int SINE_W  = 15;
	localparam int CFG_W   = 28;

	// pi in Q30 radians, used to build the quarter-wave table.
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// Register reset values: 0.9995 in Q0.16 and full scale over thirteen voices.
	localparam logic [FADE_W-1:0] FADE_RESET = 16'd65503;
	localparam logic [VOL_W-1:0]  BASE_RESET = 28'd165191049;

	localparam logic [31:0] SAMPLE_MAX = 32'h7FFFFFFF;

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_TICK    = 2'd2,
		OP_LOAD    = 2'd3
	} opcode_t;

	typedef enum logic [0:0] {
		REG_FADE = 1'b0,
		REG_BASE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// State of one voice as it sits in, and moves between, ring cells.
	typedef struct packed {
		logic [VOL_W-1:0]   volume;
		logic               held;
		logic [PHASE_W-1:0] phase;
		logic [PHASE_W-1:0] step;
	} voice_t;

	// Per-cell control.
	typedef struct packed {
		logic shift;
		logic press;
		logic release_key;
		logic load;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/pssd_cell.sv -----
// One voice cell of the rotating voice ring.
`default_nettype none

module pssd_cell
	import pssd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cell_ctrl_t         ctrl,
	input  wire voice_t             nbr,
	input  wire logic [VOL_W-1:0]   base_volume,
	input  wire logic [PHASE_W-1:0] phase_step,
	output voice_t                  st
);

	voice_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (ctrl.shift) begin
			st_q <= nbr;
		end else if (ctrl.press) begin
			st_q.volume <= base_volume;
			st_q.held   <= 1'b1;
		end else if (ctrl.release_key) begin
			st_q.held <= 1'b0;
		end else if (ctrl.load) begin
			st_q.step <= phase_step;
		end
	end

	assign st = st_q;

endmodule

`default_nettype wire

// ----- design/pssd_sine_rom.sv -----
// Quarter-wave sine table with registered read.
`default_nettype none

module pssd_sine_rom
	import pssd_pkg::*;
#(
	parameter int SINE_DEPTH = SINE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic [$clog2(SINE_DEPTH)-1:0] addr,
	output logic [SINE_W-1:0]                  data
);

	localparam logic [63:0] QDIV = 64'(4 * SINE_DEPTH);

	// Entry k is sin((2k+1) pi / (4 depth)) in Q0.15, from a Taylor series to x^13.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] acc;
		logic signed [63:0] r;
		x    = (64'(2 * k + 1) * PI_Q30) / QDIV;
		term = x;
		acc  = signed'(x);
		for (int n = 1; n <= 6; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			case (n)
				1:       term = term / 6;
				2:       term = term / 20;
				3:       term = term / 42;
				4:       term = term / 72;
				5:       term = term / 110;
				default: term = term / 156;
			endcase
			if (n[0])
				acc = acc - signed'(term);
			else
				acc = acc + signed'(term);
		end
		if (acc < 0)
			acc = 0;
		r = (acc + 64'sd16384) >>> 15;
		if (r > 64'sd32767)
			r = 64'sd32767;
		return r[SINE_W-1:0];
	endfunction

	logic [SINE_W-1:0] tab [SINE_DEPTH];

	for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_tab
		assign tab[g] = sine_entry(g);
	end

	always_ff @(posedge clk) begin
		data <= tab[addr];
	end

endmodule

`default_nettype wire

// ----- design/polyphonic_sine_synth_decay_unit.sv -----
// Top level of the polyphonic sine synthesizer with exponential release.
//
// Usage:
//   Commands enter on the slave stream: tuser carries the opcode (press,
//   release, sample tick, load step), tdata carries the voice index and the
//   Q0.32 phase step. Only a tick produces a beat on the master stream: the
//   signed 32-bit sum of volume times sine over all voices.
//   A tick sweeps the voice ring, one voice per cycle through a single
//   shared lookup and multiply path, and then drains that path; the input
//   is blocked from the accepted beat until the output beat is loaded.
//   The output register holds a finished sample while the receiver stalls;
//   commands are still taken then, and a following tick waits at its final
//   step until the register frees up.
//   Reset clears all voices (volume, held mark, phase, step), loads the
//   register defaults and empties the output. Write the configuration
//   port only while no tick is in flight.
`default_nettype none

module polyphonic_sine_synth_decay_unit
	import pssd_pkg::*;
#(
	parameter int VOICES     = VOICES_DEF,
	parameter int SINE_DEPTH = SINE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// slave command stream
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [39:0]      s_tdata,   // [3:0] voice, [35:4] phase_step, [39:36] zero
	input  wire logic [1:0]       s_tuser,   // [1:0] opcode
	// master sample stream
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [31:0]           m_tdata,   // [31:0] sample
	// configuration writes
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int KW    = $clog2(SINE_DEPTH);
	localparam int CNT_W = $clog2(VOICES + 1);
	localparam int PROD_W = VOL_W + SINE_W;
	localparam int ACC_W = PROD_W + $clog2(VOICES) + 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(signed'(SAMPLE_MAX));
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(signed'(~SAMPLE_MAX));

	// Unpack the command beat.
	opcode_t            op;
	logic [3:0]         in_voice;
	logic [PHASE_W-1:0] in_step;

	assign op       = opcode_t'(s_tuser);
	assign in_voice = s_tdata[3:0];
	assign in_step  = s_tdata[35:4];

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	// Configuration registers.
	logic [FADE_W-1:0] fade_q;
	logic [VOL_W-1:0]  base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q <= FADE_RESET;
			base_q <= BASE_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FADE: fade_q <= cfg_data[FADE_W-1:0];
				REG_BASE: base_q <= cfg_data[VOL_W-1:0];
				default:  ;
			endcase
		end
	end

	// Sequencer.
	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             v_s1, v_s2, v_s3;
	logic             out_free;
	logic             shift_en;
	logic             emit_load;

	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && op == OP_TICK)
					state_nxt = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (cnt_q == CNT_W'(VOICES - 1))
					state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3))
					state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		shift_en  = 1'b0;
		emit_load = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready  = 1'b1;
			ST_SWEEP: shift_en  = 1'b1;
			ST_DRAIN: ;
			ST_EMIT:  emit_load = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (shift_en)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

	// Voice ring: cell 0 is the head; during a sweep every cell takes its
	// upper neighbor, and the head's advanced state wraps into the last cell.
	// After VOICES shifts each voice is home again.
	voice_t cell_st [VOICES];
	voice_t cell_in [VOICES];
	voice_t head, head_nxt;
	logic [VOL_W+FADE_W-1:0] decay_prod;

	assign head       = cell_st[0];
	assign decay_prod = (VOL_W+FADE_W)'(head.volume) * (VOL_W+FADE_W)'(fade_q);

	always_comb begin
		head_nxt       = head;
		head_nxt.phase = head.phase + head.step;
		// Scale released voices; a zero volume stays zero either way.
		if (!head.held)
			head_nxt.volume = decay_prod[FADE_W +: VOL_W];
	end

	for (genvar g = 0; g < VOICES; g++) begin : g_cell
		cell_ctrl_t ctrl;
		logic       hit;

		assign hit = in_acc && (int'(in_voice) == g);
		assign ctrl.shift       = shift_en;
		assign ctrl.press       = hit && op == OP_PRESS;
		assign ctrl.release_key = hit && op == OP_RELEASE;
		assign ctrl.load        = hit && op == OP_LOAD;

		if (g == VOICES - 1) begin : g_tail
			assign cell_in[g] = head_nxt;
		end else begin : g_body
			assign cell_in[g] = cell_st[g+1];
		end

		pssd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.nbr         (cell_in[g]),
			.base_volume (base_q),
			.phase_step  (in_step),
			.st          (cell_st[g])
		);
	end

	// Stage 1: quadrant fold into a table address.
	logic [30+KW:0] pos_prod;
	logic [KW-1:0]  pos_k;
	logic [KW-1:0]  addr_s1;
	logic           neg_s1, neg_s2, neg_s3;
	logic [VOL_W-1:0] vol_s1, vol_s2;

	assign pos_prod = (31+KW)'(head.phase[29:0]) * (31+KW)'(SINE_DEPTH);
	assign pos_k    = pos_prod[30 +: KW];

	always_ff @(posedge clk) begin
		addr_s1 <= head.phase[30] ? KW'(SINE_DEPTH - 1) - pos_k : pos_k;
		neg_s1  <= head.phase[31];
		vol_s1  <= head.volume;
	end

	// Stage 2: table read.
	logic [SINE_W-1:0] sine_s2;

	pssd_sine_rom #(
		.SINE_DEPTH (SINE_DEPTH)
	) u_rom (
		.clk  (clk),
		.addr (addr_s1),
		.data (sine_s2)
	);

	always_ff @(posedge clk) begin
		vol_s2 <= vol_s1;
		neg_s2 <= neg_s1;
	end

	// Stage 3: volume times sine magnitude.
	logic [PROD_W-1:0] prod_s3;

	always_ff @(posedge clk) begin
		prod_s3 <= PROD_W'(vol_s2) * PROD_W'(sine_s2);
		neg_s3  <= neg_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= shift_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Accumulate with the quadrant sign; clear on an accepted tick.
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_ext;

	assign prod_ext = signed'(ACC_W'(prod_s3));

	always_ff @(posedge clk) begin
		if (in_acc && op == OP_TICK)
			acc_q <= '0;
		else if (v_s3)
			acc_q <= neg_s3 ? acc_q - prod_ext : acc_q + prod_ext;
	end

	// Divide by 2^15 toward zero, then clamp to 32 bits.
	logic signed [ACC_W-1:0] quot;
	logic [31:0]             sample_sat;

	always_comb begin
		if (acc_q[ACC_W-1])
			quot = (acc_q + ACC_W'(32767)) >>> 15;
		else
			quot = acc_q >>> 15;
		if (quot > SAT_HI)
			sample_sat = SAMPLE_MAX;
		else if (quot < SAT_LO)
			sample_sat = ~SAMPLE_MAX;
		else
			sample_sat = quot[31:0];
	end

	// Output register.
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (emit_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load)
			m_tdata_q <= sample_sat;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
